[hw/rtl/fws_pkg.sv]
// ----------------------------------------------------------------------------
// fws_pkg
// Shared types, codes and pattern helpers for the fill-to-aligned-write
// splitter.
// ----------------------------------------------------------------------------
package fws_pkg;

  localparam int ADDR_W  = 25;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 2;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 3;

  // bytes above which an aligned run goes out as a serial block
  localparam int SERIAL_MIN_BYTES = 12;
  localparam logic [15:0] SERIAL_HDR_TAG = 16'h0001;

  localparam logic [SIZE_W-1:0] SZ_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SZ_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SZ_WORD = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE  = 3'd0,
    KIND_HALF  = 3'd1,
    KIND_WORD  = 3'd2,
    KIND_SHDR  = 3'd3,
    KIND_SFILL = 3'd4,
    KIND_AERR  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STRIDE,
    S_SPLIT,
    S_FILL
  } state_t;

  typedef struct packed {
    logic load;
    logic emit_stride;
    logic emit_split;
    logic emit_fill;
  } dp_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic in_contig;
    logic stride_last;
    logic split_serial;
    logic split_last;
    logic fill_last;
  } dp_stat_t;

  function automatic logic [DATA_W-1:0] elem_mask(input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] m;
    unique case (sz)
      SZ_BYTE: m = 32'h0000_00FF;
      SZ_HALF: m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] word_pat(input logic [DATA_W-1:0] v,
                                                 input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] p;
    if (sz == SZ_BYTE) begin
      p = {4{v[7:0]}};
    end else begin
      p = {2{v[15:0]}};
    end
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] half_pat(input logic [DATA_W-1:0] v,
                                                 input logic [SIZE_W-1:0] sz);
    logic [DATA_W-1:0] p;
    if (sz == SZ_BYTE) begin
      p = {16'h0000, {2{v[7:0]}}};
    end else begin
      p = {16'h0000, v[15:0]};
    end
    return p;
  endfunction

endpackage

[hw/rtl/fill_to_aligned_write_splitter_top.sv]
// ----------------------------------------------------------------------------
// fill_to_aligned_write_splitter_top
// Turns one fill request into a run of aligned write or serial block commands.
// ----------------------------------------------------------------------------
// One request is taken when the sequencer is idle; it is loaded into the request
// registers, then one command per cycle goes into a single output register while
// the output is free, giving N results in all (0 to 64: none for
// a zero count, one per element for strided or incrementing requests, a
// handful for contiguous fills, which use a header plus a fill word for runs
// above 12 aligned bytes).
// Output stalls hold the sequencer; the next request is taken while the last
// result still waits for its transfer. run_last marks the final result, and an
// address error result ends a contiguous run early.
module fill_to_aligned_write_splitter_top #(
  parameter int MAX_COUNT = 64,
  parameter int ADDR_BITS = 25
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [fws_pkg::SIZE_W-1:0]  elem_size,
  input  logic        [fws_pkg::ADDR_W-1:0]  start_address,
  input  logic        [fws_pkg::DATA_W-1:0]  fill_value,
  input  logic        [fws_pkg::COUNT_W-1:0] elem_count,
  input  logic signed [fws_pkg::DATA_W-1:0]  addr_step,
  input  logic signed [fws_pkg::DATA_W-1:0]  value_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [fws_pkg::KIND_W-1:0]  cmd_kind,
  output logic        [fws_pkg::ADDR_W-1:0]  cmd_address,
  output logic        [fws_pkg::DATA_W-1:0]  cmd_data,
  output logic                               run_last
);
  import fws_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  fws_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fws_dp #(
    .MAX_COUNT (MAX_COUNT),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .elem_size     (elem_size),
    .start_address (start_address),
    .fill_value    (fill_value),
    .elem_count    (elem_count),
    .addr_step     (addr_step),
    .value_step    (value_step),
    .cmd           (cmd),
    .stat          (stat),
    .cmd_kind      (cmd_kind),
    .cmd_address   (cmd_address),
    .cmd_data      (cmd_data),
    .run_last      (run_last)
  );

endmodule

[hw/rtl/fws_ctrl.sv]
// ----------------------------------------------------------------------------
// fws_ctrl
// Sequencer: takes a request, steps the datapath one command per cycle while
// the output register is free, and owns the output valid flag.
// ----------------------------------------------------------------------------
module fws_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fws_pkg::dp_cmd_t  cmd,
  input  fws_pkg::dp_stat_t stat
);
  import fws_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   emit;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.in_zero) begin
            state_next = stat.in_contig ? S_SPLIT : S_STRIDE;
          end
        end
      end
      S_STRIDE: begin
        if (out_free) begin
          cmd.emit_stride = 1'b1;
          if (stat.stride_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_SPLIT: begin
        if (out_free) begin
          cmd.emit_split = 1'b1;
          if (stat.split_serial) begin
            state_next = S_FILL;
          end else if (stat.split_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_FILL: begin
        if (out_free) begin
          cmd.emit_fill = 1'b1;
          state_next = stat.fill_last ? S_IDLE : S_SPLIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
    emit           = cmd.emit_stride || cmd.emit_split || cmd.emit_fill;
    out_valid_next = emit || (out_valid && !out_ready);
  end

  // a serial fill word always follows its header
  a_fill_after_hdr: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_FILL) |-> $past(state) == S_SPLIT)
    else $error("fill word step entered without a serial header");

  // a pending result is never dropped before its transfer
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output result dropped without transfer");

  // never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.emit_stride || cmd.emit_split || cmd.emit_fill))
    else $error("output register overwritten while stalled");

endmodule

[hw/rtl/fws_dp.sv]
// ----------------------------------------------------------------------------
// fws_dp
// Datapath: request registers, address/value/count stepping, aligned split
// decision and the output register.
// ----------------------------------------------------------------------------
module fws_dp #(
  parameter int MAX_COUNT = 64,
  parameter int ADDR_BITS = 25
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic        [fws_pkg::SIZE_W-1:0]    elem_size,
  input  logic        [fws_pkg::ADDR_W-1:0]    start_address,
  input  logic        [fws_pkg::DATA_W-1:0]    fill_value,
  input  logic        [fws_pkg::COUNT_W-1:0]   elem_count,
  input  logic signed [fws_pkg::DATA_W-1:0]    addr_step,
  input  logic signed [fws_pkg::DATA_W-1:0]    value_step,
  input  fws_pkg::dp_cmd_t                     cmd,
  output fws_pkg::dp_stat_t                    stat,
  output logic        [fws_pkg::KIND_W-1:0]    cmd_kind,
  output logic        [fws_pkg::ADDR_W-1:0]    cmd_address,
  output logic        [fws_pkg::DATA_W-1:0]    cmd_data,
  output logic                                 run_last
);
  import fws_pkg::*;

  localparam int CNT_W   = $clog2(MAX_COUNT + 1);
  localparam int BYTES_W = $clog2(4 * MAX_COUNT + 1);
  localparam logic [31:0] ADDR_LIM = 32'hFFFF_FFFF >> (32 - ADDR_BITS);
  localparam logic [COUNT_W-1:0] CNT_CAP = COUNT_W'(MAX_COUNT);

  // request state
  logic [SIZE_W-1:0]  sz;
  logic [31:0]        addr;
  logic [DATA_W-1:0]  val;
  logic [DATA_W-1:0]  astep;
  logic [DATA_W-1:0]  vstep;
  logic [CNT_W-1:0]   cnt;
  logic [BYTES_W-1:0] bytes;
  logic [ADDR_W-1:0]  amask;

  // input decode
  logic [SIZE_W-1:0]  sz_in;
  logic [COUNT_W-1:0] cnt_in;
  logic               contig_in;
  logic               multi_in;

  // split decode
  logic               err;
  logic               al4;
  logic               al2;
  logic               serial;
  logic               word_go;
  logic               half_go;
  logic [2:0]         step;
  logic [BYTES_W-3:0] words;

  logic [KIND_W-1:0]  kind_mux;
  logic [ADDR_W-1:0]  addr_mux;
  logic [DATA_W-1:0]  data_mux;
  logic               last_mux;

  always_comb begin
    sz_in     = (elem_size > SZ_WORD) ? SZ_WORD : elem_size;
    cnt_in    = (elem_count > CNT_CAP) ? CNT_CAP : elem_count;
    contig_in = ($unsigned(addr_step) == (32'd1 << sz_in)) && (value_step == '0);
    multi_in  = (cnt_in > 7'd1);
  end

  always_comb begin
    err     = addr > ADDR_LIM;
    al4     = (addr[1:0] == 2'b00);
    al2     = !addr[0];
    serial  = !err && al4 && (32'(bytes) > 32'(SERIAL_MIN_BYTES));
    word_go = al4 && (32'(bytes) >= 32'd4);
    half_go = al2 && (32'(bytes) >= 32'd2);
    step    = word_go ? 3'd4 : (half_go ? 3'd2 : 3'd1);
    words   = bytes[BYTES_W-1:2];
  end

  always_comb begin
    stat.in_zero      = (cnt_in == '0);
    stat.in_contig    = contig_in && multi_in;
    stat.stride_last  = (cnt == CNT_W'(1));
    stat.split_serial = serial;
    stat.split_last   = err || (!serial && (bytes == BYTES_W'(step)));
    stat.fill_last    = (bytes[1:0] == 2'b00);
  end

  // result select
  always_comb begin
    kind_mux = KIND_AERR;
    addr_mux = addr[ADDR_W-1:0];
    data_mux = '0;
    last_mux = 1'b1;
    if (cmd.emit_stride) begin
      kind_mux = KIND_W'(sz);
      addr_mux = addr[ADDR_W-1:0] & amask;
      data_mux = val & elem_mask(sz);
      last_mux = stat.stride_last;
    end else if (cmd.emit_fill) begin
      kind_mux = KIND_SFILL;
      data_mux = word_pat(val, sz);
      last_mux = stat.fill_last;
    end else begin
      last_mux = stat.split_last;
      if (err) begin
        kind_mux = KIND_AERR;
      end else if (serial) begin
        kind_mux = KIND_SHDR;
        data_mux = {16'(words), SERIAL_HDR_TAG};
      end else if (word_go) begin
        kind_mux = KIND_WORD;
        data_mux = word_pat(val, sz);
      end else if (half_go) begin
        kind_mux = KIND_HALF;
        data_mux = half_pat(val, sz);
      end else begin
        kind_mux = KIND_BYTE;
        data_mux = {24'h000000, val[7:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sz    <= sz_in;
      addr  <= {{(32 - ADDR_W){1'b0}}, start_address};
      val   <= fill_value;
      astep <= $unsigned(addr_step);
      vstep <= $unsigned(value_step);
      cnt   <= cnt_in[CNT_W-1:0];
      bytes <= BYTES_W'(cnt_in) << sz_in;
      // a single contiguous element keeps its full address
      amask <= (contig_in && !multi_in) ? {ADDR_W{1'b1}} : ADDR_LIM[ADDR_W-1:0];
    end else if (cmd.emit_stride) begin
      addr <= addr + astep;
      val  <= val + vstep;
      cnt  <= cnt - CNT_W'(1);
    end else if (cmd.emit_split && !err && !serial) begin
      addr  <= addr + 32'(step);
      bytes <= bytes - BYTES_W'(step);
    end else if (cmd.emit_fill) begin
      // skip the whole serial block
      addr  <= addr + {{(32 - BYTES_W){1'b0}}, words, 2'b00};
      bytes <= {{(BYTES_W - 2){1'b0}}, bytes[1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_stride || cmd.emit_split || cmd.emit_fill) begin
      cmd_kind    <= kind_mux;
      cmd_address <= addr_mux;
      cmd_data    <= data_mux;
      run_last    <= last_mux;
    end
  end

  // a split step never takes more bytes than remain
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_split && !err && !serial) |-> (bytes >= BYTES_W'(step)))
    else $error("split step exceeds remaining bytes");

  // a strided emit always has an element left
  a_stride_cnt: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_stride |-> (cnt != '0))
    else $error("strided emit with no element left");

  // a serial fill word leaves less than a word behind
  a_fill_rest: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_fill |=> (bytes < BYTES_W'(4)))
    else $error("serial block left a full word behind");

endmodule
